// ----- hdl/srclip_pkg.sv -----
// Shared types and constants of the segment/rectangle clipper.
// No dependencies; every other file refers to it by scoped names.
package srclip_pkg;

  localparam int unsigned CoordW   = 32;  // Q16.16 coordinate
  localparam int unsigned DiffW    = 33;  // coordinate difference
  localparam int unsigned MagW     = 32;  // magnitude of a difference
  localparam int unsigned TW       = 17;  // Q1.16 parameter, one included
  localparam int unsigned QuoW     = 18;  // ratio quotient bits before saturation
  localparam int unsigned NumW     = MagW + 16;
  localparam int unsigned ProdW    = DiffW + TW + 1;
  localparam int unsigned RatioW   = QuoW + 2;
  localparam int unsigned NumEdges = 4;
  localparam int unsigned CfgIdxW  = 4;

  localparam logic [QuoW-1:0] RatioSat = QuoW'(131072);
  localparam logic [TW-1:0]   TOne     = TW'(65536);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_MIN_X = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_MAX_X = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_MIN_Z = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_MAX_Z = CfgIdxW'(3);

  // Edge order: left, right, bottom, top
  localparam int unsigned EDGE_LEFT   = 0;
  localparam int unsigned EDGE_RIGHT  = 1;
  localparam int unsigned EDGE_BOTTOM = 2;
  localparam int unsigned EDGE_TOP    = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic                     hit;
    logic [TW-1:0]            t_enter;
    logic [TW-1:0]            t_exit;
    logic signed [CoordW-1:0] enter_x;
    logic signed [CoordW-1:0] enter_y;
    logic signed [CoordW-1:0] enter_z;
    logic signed [CoordW-1:0] leave_x;
    logic signed [CoordW-1:0] leave_y;
    logic signed [CoordW-1:0] leave_z;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [CoordW-1:0]  wdata;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_z;
  } rect_t;

  typedef struct packed {
    logic par;      // direction component is zero
    logic par_rej;  // parallel and outside
    logic enter;    // p < 0
    logic neg;      // ratio is negative
  } edge_flags_t;

  typedef struct packed {
    edge_flags_t [NumEdges-1:0] flags;
    logic [2:0][CoordW-1:0]     a;  // start x, y, z
    logic [2:0][DiffW-1:0]      d;  // end - start
  } side_t;

  typedef struct packed {
    side_t                    side;
    logic [NumEdges-1:0][MagW-1:0] mag_q;
    logic [NumEdges-1:0][MagW-1:0] mag_p;
  } job_t;

endpackage

// ----- hdl/srclip_if.sv -----
// Handshake channels of the clipper: segment in, result out, configuration.
// Depends on srclip_pkg for the payload types.
interface srclip_in_if;
  logic               valid;
  logic               ready;
  srclip_pkg::in_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srclip_out_if;
  logic               valid;
  logic               ready;
  srclip_pkg::out_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srclip_cfg_if;
  logic               valid;
  logic               ready;
  srclip_pkg::cfg_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/srclip_front.sv -----
// Front end: accept a segment word and classify its four clip edges.
// Depends on srclip_pkg.
module srclip_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srclip_pkg::in_t   seg_i,
  input  srclip_pkg::rect_t rect_i,
  input  logic              full_i,
  output logic              push_o,
  output srclip_pkg::job_t  job_o
);

  logic signed [srclip_pkg::DiffW-1:0] dx, dy, dz;
  logic signed [srclip_pkg::DiffW-1:0] p [srclip_pkg::NumEdges];
  logic signed [srclip_pkg::DiffW-1:0] q [srclip_pkg::NumEdges];

  function automatic logic [srclip_pkg::MagW-1:0] mag_f(
    input logic signed [srclip_pkg::DiffW-1:0] v
  );
    logic signed [srclip_pkg::DiffW-1:0] t;
    t = v[srclip_pkg::DiffW-1] ? -v : v;
    return t[srclip_pkg::MagW-1:0];
  endfunction

  function automatic logic signed [srclip_pkg::DiffW-1:0] sx_f(
    input logic signed [srclip_pkg::CoordW-1:0] v
  );
    return {v[srclip_pkg::CoordW-1], v};
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    dx = sx_f(seg_i.end_x) - sx_f(seg_i.start_x);
    dy = sx_f(seg_i.end_y) - sx_f(seg_i.start_y);
    dz = sx_f(seg_i.end_z) - sx_f(seg_i.start_z);

    p[srclip_pkg::EDGE_LEFT]   = -dx;
    q[srclip_pkg::EDGE_LEFT]   = sx_f(seg_i.start_x) - sx_f(rect_i.min_x);
    p[srclip_pkg::EDGE_RIGHT]  = dx;
    q[srclip_pkg::EDGE_RIGHT]  = sx_f(rect_i.max_x) - sx_f(seg_i.start_x);
    p[srclip_pkg::EDGE_BOTTOM] = -dz;
    q[srclip_pkg::EDGE_BOTTOM] = sx_f(seg_i.start_z) - sx_f(rect_i.min_z);
    p[srclip_pkg::EDGE_TOP]    = dz;
    q[srclip_pkg::EDGE_TOP]    = sx_f(rect_i.max_z) - sx_f(seg_i.start_z);

    job_o.side.a[0] = seg_i.start_x;
    job_o.side.a[1] = seg_i.start_y;
    job_o.side.a[2] = seg_i.start_z;
    job_o.side.d[0] = dx;
    job_o.side.d[1] = dy;
    job_o.side.d[2] = dz;

    for (int e = 0; e < srclip_pkg::NumEdges; e++) begin
      job_o.side.flags[e].par     = (p[e] == '0);
      job_o.side.flags[e].par_rej = (p[e] == '0) && q[e][srclip_pkg::DiffW-1];
      job_o.side.flags[e].enter   = p[e][srclip_pkg::DiffW-1];
      job_o.side.flags[e].neg     = q[e][srclip_pkg::DiffW-1] ^ p[e][srclip_pkg::DiffW-1];
      job_o.mag_q[e]              = mag_f(q[e]);
      job_o.mag_p[e]              = mag_f(p[e]);
    end
  end

endmodule

// ----- hdl/srclip_fifo.sv -----
// Short job queue between the front end and the clip pipeline.
// Depends on srclip_pkg for the job word.
module srclip_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srclip_pkg::job_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output srclip_pkg::job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  srclip_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/srclip_div.sv -----
// Pipelined restoring divider: floor((mag_q << 16) / mag_p), one quotient bit
// per stage, with overflow and nonzero-remainder flags. Depends on srclip_pkg.
module srclip_div (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [srclip_pkg::NumW-1:0] num_i,
  input  logic [srclip_pkg::MagW-1:0] den_i,
  output logic [srclip_pkg::QuoW-1:0] quo_o,
  output logic                        ovf_o,
  output logic                        rem_nz_o
);

  localparam int unsigned Stages = srclip_pkg::QuoW;
  localparam int unsigned CmpW   = srclip_pkg::NumW + 2;

  logic [srclip_pkg::NumW-1:0] rem_q [Stages+1];
  logic [srclip_pkg::MagW-1:0] den_q [Stages+1];
  logic [srclip_pkg::QuoW-1:0] quo_q [Stages+1];
  logic                        ovf_q [Stages+1];

  // Quotient at or above 2^QuoW saturates anyway: flag it up front
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ({2'b00, num_i} >= {den_i, {srclip_pkg::QuoW{1'b0}}});
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [CmpW-1:0] dsh;
    logic            ge;
    assign dsh = {{(CmpW - srclip_pkg::MagW){1'b0}}, den_q[k]} << (Stages - 1 - k);
    assign ge  = ({2'b00, rem_q[k]} >= dsh);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1] <= ge ? rem_q[k] - dsh[srclip_pkg::NumW-1:0] : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][srclip_pkg::QuoW-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o    = quo_q[Stages];
  assign ovf_o    = ovf_q[Stages];
  assign rem_nz_o = (rem_q[Stages] != '0);

endmodule

// ----- hdl/srclip_back.sv -----
// Back end: four ratio dividers, interval narrowing, interpolation multiply
// and the output register. Depends on srclip_pkg and srclip_div.
module srclip_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srclip_pkg::job_t  job_i,
  input  logic              avail_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srclip_pkg::out_t  out_o
);

  localparam int unsigned DivLat = srclip_pkg::QuoW + 1;

  logic adv;
  logic pop;

  logic [DivLat-1:0] vld_q;
  srclip_pkg::side_t side_q [DivLat];

  logic [srclip_pkg::QuoW-1:0] quo    [srclip_pkg::NumEdges];
  logic                        ovf    [srclip_pkg::NumEdges];
  logic                        rem_nz [srclip_pkg::NumEdges];

  logic signed [srclip_pkg::RatioW-1:0] t0, t1;
  logic                                  hit;

  logic                       c_vld_q;
  logic                       c_hit_q;
  logic [srclip_pkg::TW-1:0]  c_t0_q, c_t1_q;
  srclip_pkg::side_t          c_side_q;

  logic                                  m_vld_q;
  logic                                  m_hit_q;
  logic [srclip_pkg::TW-1:0]             m_t0_q, m_t1_q;
  logic [2:0][srclip_pkg::CoordW-1:0]    m_a_q;
  logic signed [srclip_pkg::ProdW-1:0]   m_p0_q [3];
  logic signed [srclip_pkg::ProdW-1:0]   m_p1_q [3];

  logic             out_valid_q;
  srclip_pkg::out_t out_q, out_d;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop   = adv && avail_i;
  assign pop_o = pop;

  for (genvar e = 0; e < srclip_pkg::NumEdges; e++) begin : g_div
    srclip_div u_div (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .num_i    ({job_i.mag_q[e], 16'h0000}),
      .den_i    (job_i.mag_p[e]),
      .quo_o    (quo[e]),
      .ovf_o    (ovf[e]),
      .rem_nz_o (rem_nz[e])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      c_vld_q     <= 1'b0;
      m_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[DivLat-2:0], pop};
      c_vld_q     <= vld_q[DivLat-1];
      m_vld_q     <= c_vld_q;
      out_valid_q <= m_vld_q;
    end
  end

  // Side data rides alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= job_i.side;
      for (int s = 1; s < DivLat; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Round toward minus infinity, saturate, then narrow [t0, t1]
  always_comb begin
    logic [srclip_pkg::QuoW:0]             sum;
    logic [srclip_pkg::QuoW-1:0]           mag;
    logic signed [srclip_pkg::RatioW-1:0]  r;
    logic                                  rej;
    t0  = '0;
    t1  = srclip_pkg::RatioW'(srclip_pkg::TOne);
    rej = 1'b0;
    for (int e = 0; e < srclip_pkg::NumEdges; e++) begin
      sum = {1'b0, quo[e]} +
            (srclip_pkg::QuoW+1)'(side_q[DivLat-1].flags[e].neg && rem_nz[e]);
      mag = (ovf[e] || (sum > {1'b0, srclip_pkg::RatioSat})) ? srclip_pkg::RatioSat
                                                               : sum[srclip_pkg::QuoW-1:0];
      r   = side_q[DivLat-1].flags[e].neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      rej = rej || side_q[DivLat-1].flags[e].par_rej;
      if (!side_q[DivLat-1].flags[e].par) begin
        if (side_q[DivLat-1].flags[e].enter) begin
          if (r > t0) t0 = r;
        end else begin
          if (r < t1) t1 = r;
        end
      end
    end
    hit = !rej && !(t0 > t1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_hit_q  <= hit;
      c_t0_q   <= hit ? t0[srclip_pkg::TW-1:0] : '0;
      c_t1_q   <= hit ? t1[srclip_pkg::TW-1:0] : '0;
      c_side_q <= side_q[DivLat-1];
    end
  end

  // d * t for the entry and the exit point of each axis
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_hit_q <= c_hit_q;
      m_t0_q  <= c_t0_q;
      m_t1_q  <= c_t1_q;
      m_a_q   <= c_side_q.a;
      for (int i = 0; i < 3; i++) begin
        m_p0_q[i] <= $signed(c_side_q.d[i]) * $signed({1'b0, c_t0_q});
        m_p1_q[i] <= $signed(c_side_q.d[i]) * $signed({1'b0, c_t1_q});
      end
    end
  end

  // Floor by 2^16 is the bit slice; the point always fits the coordinate width
  always_comb begin
    logic [2:0][srclip_pkg::CoordW-1:0] pe, pl;
    for (int i = 0; i < 3; i++) begin
      pe[i] = m_a_q[i] + m_p0_q[i][srclip_pkg::CoordW+15:16];
      pl[i] = m_a_q[i] + m_p1_q[i][srclip_pkg::CoordW+15:16];
    end
    out_d.hit     = m_hit_q;
    out_d.t_enter = m_t0_q;
    out_d.t_exit  = m_t1_q;
    out_d.enter_x = m_hit_q ? pe[0] : '0;
    out_d.enter_y = m_hit_q ? pe[1] : '0;
    out_d.enter_z = m_hit_q ? pe[2] : '0;
    out_d.leave_x = m_hit_q ? pl[0] : '0;
    out_d.leave_y = m_hit_q ? pl[1] : '0;
    out_d.leave_z = m_hit_q ? pl[2] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- hdl/segment_rect_clip.sv -----
// Liang-Barsky clip of a 3D segment against an XZ rectangle, Q16.16 fixed point.
// Path: job queue, four pipelined 18-stage ratio dividers, narrowing, multiply, output.
// Throughput: one segment per cycle while the output is not stalled.
// The job queue lets the front end keep accepting while the output stalls, until full.
// Reset: asynchronous, active low; clears the rectangle bounds, queue and valids.
// Depends on srclip_pkg, srclip_if, srclip_front, srclip_fifo, srclip_back.
module segment_rect_clip #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  srclip_cfg_if.sink          cfg,
  srclip_in_if.sink           seg_in,
  srclip_out_if.source        res_out
);

  srclip_pkg::rect_t rect_q;
  srclip_pkg::job_t  front_job;
  srclip_pkg::job_t  fifo_job;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;

  // Configuration writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.idx)
        srclip_pkg::CFG_MIN_X: rect_q.min_x <= cfg.data.wdata;
        srclip_pkg::CFG_MAX_X: rect_q.max_x <= cfg.data.wdata;
        srclip_pkg::CFG_MIN_Z: rect_q.min_z <= cfg.data.wdata;
        srclip_pkg::CFG_MAX_Z: rect_q.max_z <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  // Front: form direction, edge distances and edge classes of each word
  srclip_front u_front (
    .in_valid_i (seg_in.valid),
    .in_ready_o (seg_in.ready),
    .seg_i      (seg_in.data),
    .rect_i     (rect_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (front_job)
  );

  // Queue: decouple acceptance from the stall of the result side
  srclip_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (fifo_job)
  );

  // Back: divide, narrow the interval, interpolate, hold the result word
  srclip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (fifo_job),
    .avail_i     (!empty),
    .pop_o       (pop),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .out_o       (res_out.data)
  );

endmodule

// ----- sim/tb_segment_rect_clip.sv -----
// Self-checking testbench of segment_rect_clip: segments are clipped by an
// in-bench Liang-Barsky predictor and compared with every result word.
// Depends on srclip_pkg, srclip_if and the clipper RTL.
module tb_segment_rect_clip;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   err_count = 0;

  srclip_cfg_if cfg_ch ();
  srclip_in_if  seg_ch ();
  srclip_out_if res_ch ();

  segment_rect_clip uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_ch.sink),
    .seg_in  (seg_ch.sink),
    .res_out (res_ch.source)
  );

  // Count a mismatch and print one line for it.
  task automatic report(input string msg);
    err_count++;
    $display("ERROR @%0d: %s", cycles, msg);
  endtask

  // Clip predictor with its own copy of the rectangle, plus the queue of
  // expected result words.
  class clip_scoreboard;
    srclip_pkg::rect_t box;
    srclip_pkg::out_t  pending[$];

    // Floor of q*65536/p, saturated to +-2.0 in Q16.16.
    function longint ratio(longint q, longint p);
      longint num, quo;
      num = q * 65536;
      quo = num / p;
      if ((num % p != 0) && ((num < 0) != (p < 0))) quo = quo - 1;
      if (quo > 131072) quo = 131072;
      if (quo < -131072) quo = -131072;
      return quo;
    endfunction

    // Narrow [t0,t1] by one edge; return 0 on rejection.
    function bit clip_edge(longint p, longint q, ref longint t0, ref longint t1);
      longint r;
      if (p == 0) return q >= 0;
      r = ratio(q, p);
      if (p < 0) begin
        if (r > t1) return 0;
        if (r > t0) t0 = r;
      end else begin
        if (r < t0) return 0;
        if (r < t1) t1 = r;
      end
      return 1;
    endfunction

    function longint lerp(longint a, longint b, longint t);
      longint v;
      v = (b - a) * t;
      // arithmetic shift floors toward minus infinity
      return a + (v >>> 16);
    endfunction

    function void note_segment(srclip_pkg::in_t s);
      longint ax, ay, az, bx, by, bz, t0, t1;
      bit ok;
      srclip_pkg::out_t o;
      ax = s.start_x; ay = s.start_y; az = s.start_z;
      bx = s.end_x;   by = s.end_y;   bz = s.end_z;
      t0 = 0; t1 = 65536;
      o = '0;
      ok = clip_edge(ax - bx, ax - longint'(box.min_x), t0, t1)
        && clip_edge(bx - ax, longint'(box.max_x) - ax, t0, t1)
        && clip_edge(az - bz, az - longint'(box.min_z), t0, t1)
        && clip_edge(bz - az, longint'(box.max_z) - az, t0, t1)
        && !(t0 > t1);
      if (ok) begin
        if (t0 < 0) t0 = 0;
        if (t0 > 65536) t0 = 65536;
        if (t1 < 0) t1 = 0;
        if (t1 > 65536) t1 = 65536;
        if (t0 <= t1) begin
          o.hit = 1'b1;
          o.t_enter = srclip_pkg::TW'(t0);
          o.t_exit = srclip_pkg::TW'(t1);
          o.enter_x = srclip_pkg::CoordW'(lerp(ax, bx, t0));
          o.enter_y = srclip_pkg::CoordW'(lerp(ay, by, t0));
          o.enter_z = srclip_pkg::CoordW'(lerp(az, bz, t0));
          o.leave_x = srclip_pkg::CoordW'(lerp(ax, bx, t1));
          o.leave_y = srclip_pkg::CoordW'(lerp(ay, by, t1));
          o.leave_z = srclip_pkg::CoordW'(lerp(az, bz, t1));
        end
      end
      pending.push_back(o);
    endfunction

    task check_result(srclip_pkg::out_t got);
      srclip_pkg::out_t e;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) report($sformatf("hit %0b exp %0b", got.hit, e.hit));
      if (got.t_enter !== e.t_enter)
        report($sformatf("t_enter %0d exp %0d", got.t_enter, e.t_enter));
      if (got.t_exit !== e.t_exit)
        report($sformatf("t_exit %0d exp %0d", got.t_exit, e.t_exit));
      if (got.enter_x !== e.enter_x)
        report($sformatf("enter_x %h exp %h", got.enter_x, e.enter_x));
      if (got.enter_y !== e.enter_y)
        report($sformatf("enter_y %h exp %h", got.enter_y, e.enter_y));
      if (got.enter_z !== e.enter_z)
        report($sformatf("enter_z %h exp %h", got.enter_z, e.enter_z));
      if (got.leave_x !== e.leave_x)
        report($sformatf("leave_x %h exp %h", got.leave_x, e.leave_x));
      if (got.leave_y !== e.leave_y)
        report($sformatf("leave_y %h exp %h", got.leave_y, e.leave_y));
      if (got.leave_z !== e.leave_z)
        report($sformatf("leave_z %h exp %h", got.leave_z, e.leave_z));
    endtask
  endclass

  clip_scoreboard clipper = new();
  bit stalls_on = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Free-running cycle counter; end the run if it ever gets this far.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("FAIL segment_rect_clip");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if (!stalls_on) return 0;
    if ($urandom_range(9) < 5) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Receiver: random ready, check each accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) clipper.check_result(res_ch.data);
  end

  initial begin
    res_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (gap_len() > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
    end
  end

  // Write one register; hold valid until it is taken.
  task automatic write_reg(input logic [srclip_pkg::CfgIdxW-1:0] idx,
                           input logic [srclip_pkg::CoordW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{idx: idx, wdata: val};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      srclip_pkg::CFG_MIN_X: clipper.box.min_x = val;
      srclip_pkg::CFG_MAX_X: clipper.box.max_x = val;
      srclip_pkg::CFG_MIN_Z: clipper.box.min_z = val;
      default:               clipper.box.max_z = val;
    endcase
  endtask

  task automatic set_rect(input logic [srclip_pkg::CoordW-1:0] x0, x1, z0, z1);
    write_reg(srclip_pkg::CFG_MIN_X, x0);
    write_reg(srclip_pkg::CFG_MAX_X, x1);
    write_reg(srclip_pkg::CFG_MIN_Z, z0);
    write_reg(srclip_pkg::CFG_MAX_Z, z1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Send one segment word, with an optional gap first; note it when taken.
  task automatic send_segment(input srclip_pkg::in_t s);
    int g;
    g = gap_len();
    if (g > 0) begin
      seg_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.data <= s;
    @(posedge clk_i);
    while (!seg_ch.ready) @(posedge clk_i);
    clipper.note_segment(s);
  endtask

  // Drop valid and hold until every result has come, plus pipeline slack.
  task automatic drain();
    seg_ch.valid <= 1'b0;
    while (clipper.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Coordinate near the rectangle most of the time, extremes now and then.
  function automatic logic [srclip_pkg::CoordW-1:0] pick_coord(int unsigned lo_hi_span);
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(2 * lo_hi_span)) - $signed(lo_hi_span);
    endcase
  endfunction

  function automatic srclip_pkg::in_t rand_segment(int unsigned span);
    srclip_pkg::in_t s;
    s.start_x = pick_coord(span);
    s.start_y = $urandom();
    s.start_z = pick_coord(span);
    s.end_x = ($urandom_range(7) == 0) ? s.start_x : pick_coord(span);
    s.end_y = $urandom();
    s.end_z = ($urandom_range(7) == 0) ? s.start_z : pick_coord(span);
    return s;
  endfunction

  localparam logic [srclip_pkg::CoordW-1:0] MaxC = 32'h7fffffff;
  localparam logic [srclip_pkg::CoordW-1:0] MinC = 32'h80000000;

  initial begin
    srclip_pkg::in_t s;
    int unsigned span;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    seg_ch.valid = 1'b0;
    seg_ch.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset rectangle is a point at the origin: cross it and miss it.
    send_segment('{-32'sd65536, 0, 0, 32'sd65536, 0, 0});
    send_segment('{32'sd65536, 0, 32'sd65536, 32'sd131072, 0, 0});
    drain();

    // Directed: unit-ish box from -2.0 to 2.0.
    set_rect(-32'sd131072, 32'sd131072, -32'sd131072, 32'sd131072);
    // fully inside
    send_segment('{0, 32'sd5, 0, 32'sd65536, -32'sd7, 32'sd65536});
    // crosses the left and right edges, y extremes
    send_segment('{-32'sd262144, MinC, 0, 32'sd262144, MaxC, 0});
    // parallel in x and outside: rejected
    send_segment('{32'sd300000, 0, -32'sd300000, 32'sd300000, 0, 32'sd300000});
    // parallel in z and inside
    send_segment('{-32'sd300000, 0, 32'sd100, 32'sd300000, 0, 32'sd100});
    // zero-length point inside and outside
    send_segment('{32'sd10, 32'sd10, 32'sd10, 32'sd10, 32'sd10, 32'sd10});
    send_segment('{32'sd400000, 0, 0, 32'sd400000, 0, 0});
    // diagonal through corners, reversed direction
    send_segment('{32'sd262144, 32'sd1, 32'sd262144, -32'sd262144, -32'sd1, -32'sd262144});
    // extreme coordinates: saturating ratios
    send_segment('{MinC, MinC, MinC, MaxC, MaxC, MaxC});
    send_segment('{MaxC, MaxC, MinC, MinC, MinC, MaxC});
    // starts exactly on the edge; misses the corner
    send_segment('{32'sd131072, 0, 0, 32'sd200000, 0, 0});
    send_segment('{32'sd100000, 0, 32'sd300000, 32'sd300000, 0, 32'sd100000});
    // tiny step: ratios far beyond one
    send_segment('{0, 0, 0, 32'sd1, 32'sd1, -32'sd1});
    drain();

    // Degenerate box (min > max) and the widest box.
    set_rect(32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536);
    send_segment('{-32'sd131072, 0, 0, 32'sd131072, 0, 0});
    send_segment('{0, 0, -32'sd131072, 0, 0, 32'sd131072});
    drain();
    set_rect(MinC, MaxC, MinC, MaxC);
    send_segment('{MinC, MinC, MinC, MaxC, MaxC, MaxC});
    send_segment('{MaxC, 0, MaxC, MinC, 0, MinC});
    drain();

    // Random phases, each with its own rectangle.
    for (int ph = 0; ph < 8; ph++) begin
      span = (ph == 7) ? 32'h7fffffff : ($urandom_range(1) ? 32'h40000 : 32'h4000000);
      stalls_on = (ph != 3);
      if (ph == 6) set_rect(MaxC, MinC, MaxC, MinC);
      else set_rect(pick_coord(span), pick_coord(span) + span / 2,
                    pick_coord(span), pick_coord(span) + span / 2);
      for (int i = 0; i < 200; i++) begin
        s = rand_segment(span);
        send_segment(s);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("PASS segment_rect_clip");
    end else begin
      $display("FAIL segment_rect_clip");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/srclip_pkg.sv
hdl/srclip_if.sv
hdl/srclip_front.sv
hdl/srclip_fifo.sv
hdl/srclip_div.sv
hdl/srclip_back.sv
hdl/segment_rect_clip.sv
sim/tb_segment_rect_clip.sv
